// File: design/sphere_vertex_generator_defines.svh
// Assertion macros for the sphere vertex generator checker.
// Needs a clock named clock and a reset named reset in scope.
`ifndef SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SVG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SVG_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/svg_pkg.sv
// Shared types, constants and arithmetic helpers of the sphere vertex generator.
// No dependencies.
package svg_pkg;

   localparam int FRAC_BITS    = 14;
   localparam int WORK_BITS    = 30;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_BITS     = 32;
   localparam int MAX_DIV      = 256;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

   localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
   localparam logic signed [15:0] UNIT_ONE = 16'sd1 <<< FRAC_BITS;

   localparam logic signed [32:0] ATAN_TABLE [24] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
      33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
      33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
      33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81
   };

   typedef enum logic [1:0] {CLS_ERR, CLS_TOP, CLS_BOT, CLS_RING} cls_type;
   typedef enum logic [1:0] {ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_RANGE = 2'd2} status_type;
   typedef enum logic [1:0] {CSR_RADIUS = 2'd0, CSR_SLICES = 2'd1, CSR_STACKS = 2'd2}
      csr_index_type;

   typedef struct packed {
      cls_type     cls;
      status_type  status;
      logic [15:0] total;
      logic [15:0] vnum;
   } tag_type;

   typedef struct packed {
      tag_type    tag;
      logic [9:0] n_pol;
      logic [9:0] d_pol;
      logic [9:0] n_az;
      logic [9:0] d_az;
   } item_type;

   // Round to nearest, ties away from zero, dropping FRAC_BITS bits.
   function automatic logic signed [39:0] rnd_frac(input logic signed [39:0] v);
      logic [39:0] mag;
      mag = v[39] ? 40'(-v) : 40'(v);
      mag = (mag + (40'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[39] ? -$signed(mag) : $signed(mag);
   endfunction

   // Q2.30 working value to Q1.14, rounded and saturated to +-1.0.
   function automatic logic signed [15:0] to_unit(input logic signed [33:0] w);
      logic signed [35:0] m;
      m = w[33] ? -36'(w) : 36'(w);
      m = (m + (36'sd1 <<< (WORK_BITS - FRAC_BITS - 1))) >>> (WORK_BITS - FRAC_BITS);
      if (w[33]) m = -m;
      if (m > 36'(UNIT_ONE)) m = 36'(UNIT_ONE);
      if (m < -36'(UNIT_ONE)) m = -36'(UNIT_ONE);
      return m[15:0];
   endfunction

endpackage

// File: design/svg_fifo.sv
// Short item queue between the front end and the compute pipeline.
// Depends on svg_pkg.
module svg_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  svg_pkg::item_type push_data,
   output logic              full,
   input  logic              pop,
   output svg_pkg::item_type pop_data,
   output logic              empty
);
   import svg_pkg::*;

   item_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + FIFO_AW'(push);
      rd_in  = rd_ff + FIFO_AW'(pop);
      cnt_in = cnt_ff + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

// File: design/svg_front.sv
// Front end: configuration registers and item classification.
// Depends on svg_pkg.
module svg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  logic [8:0]        stack_index,
   input  logic [7:0]        slice_index,
   output logic [15:0]       radius,
   output svg_pkg::item_type item
);
   import svg_pkg::*;

   logic [15:0] radius_ff;
   logic [8:0]  slices_ff, stacks_ff;
   logic        cfg_bad, top, bot, range_bad;
   logic [17:0] total_w, vnum_w;

   assign csr_ready = 1'b1;
   assign radius    = radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         slices_ff <= 9'd16;
         stacks_ff <= 9'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data;
            CSR_SLICES: slices_ff <= csr_data[8:0];
            CSR_STACKS: stacks_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg_bad   = (slices_ff == '0) || (stacks_ff < 9'd2) ||
                  (slices_ff > 9'(MAX_DIV)) || (stacks_ff > 9'(MAX_DIV));
      top       = (stack_index == '0);
      bot       = (stack_index == stacks_ff);
      range_bad = (stack_index > stacks_ff) ||
                  (!top && !bot && ({1'b0, slice_index} >= slices_ff));
      total_w   = 18'(slices_ff) * 18'(stacks_ff - 9'd1) + 18'd2;
      vnum_w    = 18'd1 + 18'(stack_index - 9'd1) * 18'(slices_ff) + 18'(slice_index);

      item.n_pol = {1'b0, stack_index};
      item.d_pol = {stacks_ff, 1'b0};
      item.n_az  = {2'b00, slice_index};
      item.d_az  = {1'b0, slices_ff};
      item.tag.total = total_w[15:0];
      item.tag.vnum  = '0;
      item.tag.status = ST_OK;
      if (cfg_bad) begin
         item.tag.cls    = CLS_ERR;
         item.tag.status = ST_EMPTY;
         item.tag.total  = '0;
      end else if (range_bad) begin
         item.tag.cls    = CLS_ERR;
         item.tag.status = ST_RANGE;
         item.tag.total  = '0;
      end else if (top) begin
         item.tag.cls = CLS_TOP;
      end else if (bot) begin
         item.tag.cls  = CLS_BOT;
         item.tag.vnum = total_w[15:0] - 16'd1;
      end else begin
         item.tag.cls  = CLS_RING;
         item.tag.vnum = vnum_w[15:0];
      end
   end
endmodule

// File: design/svg_back.sv
// Compute pipeline: angle division, two CORDIC rotators, products, output register.
// Depends on svg_pkg.
module svg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       radius,
   input  svg_pkg::item_type item,
   input  logic              item_valid,
   output logic              item_take,
   input  logic              out_pop,
   output logic              out_valid,
   output logic signed [16:0] pos_x,
   output logic signed [16:0] pos_y,
   output logic signed [16:0] pos_z,
   output logic signed [15:0] norm_x,
   output logic signed [15:0] norm_y,
   output logic signed [15:0] norm_z,
   output logic [15:0]       vertex_number,
   output logic [15:0]       vertex_total,
   output logic [1:0]        status
);
   import svg_pkg::*;

   localparam int P_CRD   = DIV_BITS;
   localparam int P_UNIT  = P_CRD + CORDIC_STEPS;
   localparam int P_PROD2 = P_UNIT + 3;
   localparam int NST     = P_UNIT + 5;

   logic    adv;
   logic    vld_ff [NST];
   logic    vld_in [NST];
   tag_type tag_ff [NST];
   tag_type tag_in [NST];

   // divider: [0] polar, [1] azimuth
   logic [9:0]  rem_ff [DIV_BITS][2];
   logic [9:0]  rem_in [DIV_BITS][2];
   logic [9:0]  div_ff [DIV_BITS][2];
   logic [9:0]  div_in [DIV_BITS][2];
   logic [31:0] quo_ff [DIV_BITS][2];
   logic [31:0] quo_in [DIV_BITS][2];

   logic signed [33:0] cx_ff [CORDIC_STEPS][2];
   logic signed [33:0] cx_in [CORDIC_STEPS][2];
   logic signed [33:0] cy_ff [CORDIC_STEPS][2];
   logic signed [33:0] cy_in [CORDIC_STEPS][2];
   logic signed [32:0] cz_ff [CORDIC_STEPS][2];
   logic signed [32:0] cz_in [CORDIC_STEPS][2];
   logic               fl_ff [CORDIC_STEPS][2];
   logic               fl_in [CORDIC_STEPS][2];
   logic               az0_ff [CORDIC_STEPS];
   logic               az0_in [CORDIC_STEPS];

   logic signed [15:0] cp_ff, sp_ff, ca_ff, sa_ff;
   logic signed [31:0] px1_ff, py1_ff;
   logic signed [15:0] nz1_ff, nx2_ff, ny2_ff, nz2_ff, nx3_ff, ny3_ff, nz3_ff;
   logic signed [32:0] mx_ff, my_ff, mz_ff;

   logic [10:0]        r2;
   logic [9:0]         rprev, dprev;
   logic [31:0]        qprev, ang;
   logic signed [32:0] zf;
   logic               flf;
   logic signed [33:0] xp, yp;
   logic signed [33:0] xl_p, yl_p, xl_a, yl_a;
   logic signed [16:0] rad_s;
   logic signed [39:0] nx_rnd, ny_rnd, px_rnd, py_rnd, pz_rnd;

   assign adv       = !vld_ff[NST-1] || out_pop;
   assign item_take = adv && item_valid;
   assign out_valid = vld_ff[NST-1];
   assign rad_s     = $signed({1'b0, radius});

   always_comb begin
      for (int k = 0; k < NST; k++) begin
         vld_in[k] = (k == 0) ? item_valid : vld_ff[k-1];
         tag_in[k] = (k == 0) ? item.tag : tag_ff[k-1];
      end

      // one quotient bit per stage: q = floor(n * 2^32 / d), n < d
      for (int k = 0; k < DIV_BITS; k++) begin
         for (int p = 0; p < 2; p++) begin
            if (k == 0) begin
               rprev = (p == 0) ? item.n_pol : item.n_az;
               dprev = (p == 0) ? item.d_pol : item.d_az;
               qprev = '0;
            end else begin
               rprev = rem_ff[k-1][p];
               dprev = div_ff[k-1][p];
               qprev = quo_ff[k-1][p];
            end
            r2 = {rprev, 1'b0};
            div_in[k][p] = dprev;
            if (r2 >= {1'b0, dprev}) begin
               rem_in[k][p] = 10'(r2 - {1'b0, dprev});
               quo_in[k][p] = {qprev[30:0], 1'b1};
            end else begin
               rem_in[k][p] = r2[9:0];
               quo_in[k][p] = {qprev[30:0], 1'b0};
            end
         end
      end

      for (int k = 0; k < CORDIC_STEPS; k++) begin
         for (int p = 0; p < 2; p++) begin
            if (k == 0) begin
               // polar quotient is over 2*stacks; azimuth is negated
               ang = (p == 0) ? quo_ff[DIV_BITS-1][0] : -quo_ff[DIV_BITS-1][1];
               zf  = 33'($signed(ang));
               flf = 1'b0;
               if (zf > (33'sd1 <<< 30)) begin
                  zf  = zf - (33'sd1 <<< 31);
                  flf = 1'b1;
               end else if (zf < -(33'sd1 <<< 30)) begin
                  zf  = zf + (33'sd1 <<< 31);
                  flf = 1'b1;
               end
               xp = INV_GAIN;
               yp = '0;
            end else begin
               zf  = cz_ff[k-1][p];
               flf = fl_ff[k-1][p];
               xp  = cx_ff[k-1][p];
               yp  = cy_ff[k-1][p];
            end
            fl_in[k][p] = flf;
            if (!zf[32]) begin
               cx_in[k][p] = xp - (yp >>> k);
               cy_in[k][p] = yp + (xp >>> k);
               cz_in[k][p] = zf - ATAN_TABLE[k];
            end else begin
               cx_in[k][p] = xp + (yp >>> k);
               cy_in[k][p] = yp - (xp >>> k);
               cz_in[k][p] = zf + ATAN_TABLE[k];
            end
         end
         az0_in[k] = (k == 0) ? (quo_ff[DIV_BITS-1][1] == '0) : az0_ff[k-1];
      end
   end

   // unit conversion operands and rounded products
   always_comb begin
      xl_p = fl_ff[CORDIC_STEPS-1][0] ? -cx_ff[CORDIC_STEPS-1][0] : cx_ff[CORDIC_STEPS-1][0];
      yl_p = fl_ff[CORDIC_STEPS-1][0] ? -cy_ff[CORDIC_STEPS-1][0] : cy_ff[CORDIC_STEPS-1][0];
      xl_a = fl_ff[CORDIC_STEPS-1][1] ? -cx_ff[CORDIC_STEPS-1][1] : cx_ff[CORDIC_STEPS-1][1];
      yl_a = fl_ff[CORDIC_STEPS-1][1] ? -cy_ff[CORDIC_STEPS-1][1] : cy_ff[CORDIC_STEPS-1][1];
      nx_rnd = rnd_frac(40'(px1_ff));
      ny_rnd = rnd_frac(40'(py1_ff));
      px_rnd = rnd_frac(40'(mx_ff));
      py_rnd = rnd_frac(40'(my_ff));
      pz_rnd = rnd_frac(40'(mz_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NST; k++) vld_ff[k] <= vld_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NST; k++) tag_ff[k] <= tag_in[k];
         rem_ff <= rem_in;
         div_ff <= div_in;
         quo_ff <= quo_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         cz_ff  <= cz_in;
         fl_ff  <= fl_in;
         az0_ff <= az0_in;

         // unit conversion; azimuth zero is exact
         cp_ff <= to_unit(xl_p);
         sp_ff <= to_unit(yl_p);
         ca_ff <= az0_ff[CORDIC_STEPS-1] ? UNIT_ONE : to_unit(xl_a);
         sa_ff <= az0_ff[CORDIC_STEPS-1] ? 16'sd0 : to_unit(yl_a);

         px1_ff <= ca_ff * sp_ff;
         py1_ff <= sa_ff * sp_ff;
         nz1_ff <= cp_ff;

         nx2_ff <= nx_rnd[15:0];
         ny2_ff <= ny_rnd[15:0];
         nz2_ff <= nz1_ff;

         mx_ff  <= nx2_ff * rad_s;
         my_ff  <= ny2_ff * rad_s;
         mz_ff  <= nz2_ff * rad_s;
         nx3_ff <= nx2_ff;
         ny3_ff <= ny2_ff;
         nz3_ff <= nz2_ff;

         // output register: select by class
         vertex_number <= tag_ff[P_PROD2].vnum;
         vertex_total  <= tag_ff[P_PROD2].total;
         status        <= tag_ff[P_PROD2].status;
         pos_x  <= '0;
         pos_y  <= '0;
         pos_z  <= '0;
         norm_x <= '0;
         norm_y <= '0;
         norm_z <= '0;
         case (tag_ff[P_PROD2].cls)
            CLS_TOP: begin
               pos_z  <= rad_s;
               norm_z <= UNIT_ONE;
            end
            CLS_BOT: begin
               pos_z  <= -rad_s;
               norm_z <= -UNIT_ONE;
            end
            CLS_RING: begin
               pos_x  <= px_rnd[16:0];
               pos_y  <= py_rnd[16:0];
               pos_z  <= pz_rnd[16:0];
               norm_x <= nx3_ff;
               norm_y <= ny3_ff;
               norm_z <= nz3_ff;
            end
            default: ;
         endcase
      end
   end
endmodule

// File: design/sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator.
// Depends on svg_pkg, svg_front, svg_fifo and svg_back.
//
// Usage:
//   Input queue: drive req_stack_index/req_slice_index with req_push; a beat
//   is taken when req_push is high and req_full low. One beat gives one vertex.
//   Result queue: while rsp_empty is low the oldest vertex sits on the rsp_
//   ports; pop it with rsp_pop.
//   Configuration: csr_valid/csr_ready write channel, index 0 radius (Q8.8),
//   1 slice count, 2 stack count. csr_ready is always high; write only idle.
//   Throughput: one vertex per cycle, sustained while results are popped.
//   Path: an accepted beat lands in the 4-entry input queue, then passes 32
//   divider stages (one quotient bit each), 16 CORDIC stages, four product
//   and rounding stages and the output register.
//   Stall: when the result is not popped, the whole compute pipeline holds;
//   the input queue keeps taking beats until its four entries are full.
//   Reset: synchronous, active high; empties both queues and restores
//   radius 1.0 and 16 slices by 16 stacks.
module sphere_vertex_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [8:0]        req_stack_index,
   input  logic [7:0]        req_slice_index,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [15:0]       rsp_vertex_number,
   output logic [15:0]       rsp_vertex_total,
   output logic [1:0]        rsp_status,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import svg_pkg::*;

   item_type    front_item, head_item;
   logic [15:0] radius;
   logic        fifo_full, fifo_empty, take, out_valid;

   assign req_full  = fifo_full;
   assign rsp_empty = !out_valid;

   svg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .stack_index (req_stack_index),
      .slice_index (req_slice_index),
      .radius      (radius),
      .item        (front_item)
   );

   svg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !fifo_full),
      .push_data (front_item),
      .full      (fifo_full),
      .pop       (take),
      .pop_data  (head_item),
      .empty     (fifo_empty)
   );

   svg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .radius        (radius),
      .item          (head_item),
      .item_valid    (!fifo_empty),
      .item_take     (take),
      .out_pop       (rsp_pop),
      .out_valid     (out_valid),
      .pos_x         (rsp_pos_x),
      .pos_y         (rsp_pos_y),
      .pos_z         (rsp_pos_z),
      .norm_x        (rsp_norm_x),
      .norm_y        (rsp_norm_y),
      .norm_z        (rsp_norm_z),
      .vertex_number (rsp_vertex_number),
      .vertex_total  (rsp_vertex_total),
      .status        (rsp_status)
   );
endmodule

// File: design/svg_checker.sv
// Port-level checker for the sphere vertex generator, bound to the top level.
// Depends on svg_pkg and sphere_vertex_generator_defines.svh.
`include "sphere_vertex_generator_defines.svh"

module svg_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_pop,
   input logic              rsp_empty,
   input logic signed [16:0] rsp_pos_x,
   input logic signed [16:0] rsp_pos_y,
   input logic signed [16:0] rsp_pos_z,
   input logic signed [15:0] rsp_norm_x,
   input logic signed [15:0] rsp_norm_y,
   input logic signed [15:0] rsp_norm_z,
   input logic [15:0]       rsp_vertex_number,
   input logic [15:0]       rsp_vertex_total,
   input logic [1:0]        rsp_status
);
   import svg_pkg::*;

   `SVG_ASSERT_RST(a_reset_empty, reset |=> rsp_empty, "result queue not empty after reset")
   `SVG_ASSERT(a_status_code, rsp_empty || rsp_status == ST_OK || rsp_status == ST_EMPTY || rsp_status == ST_RANGE, "bad status code")
   `SVG_ASSERT(a_err_zero, (!rsp_empty && rsp_status != ST_OK) |-> (rsp_vertex_total == 0 && rsp_vertex_number == 0 && rsp_pos_x == 0 && rsp_pos_y == 0 && rsp_pos_z == 0 && rsp_norm_x == 0 && rsp_norm_y == 0 && rsp_norm_z == 0), "error beat with nonzero fields")
   `SVG_ASSERT(a_vnum_range, (!rsp_empty && rsp_status == ST_OK) |-> (rsp_vertex_number < rsp_vertex_total), "vertex number past total")
   `SVG_ASSERT(a_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_vertex_number) && $stable(rsp_pos_x)), "stalled result changed")
endmodule

bind sphere_vertex_generator svg_checker u_svg_checker (.*);
